// File: hdl/clnw_pkg.sv
// shared types, constants and command tables of the lcd nibble writer
package clnw_pkg;

   // expander byte bits
   localparam logic [7:0] BL_BIT      = 8'h08;
   localparam logic [7:0] EN_BIT      = 8'h04;
   localparam logic [7:0] RS_BIT      = 8'h01;
   localparam logic [7:0] EN_CLR_MASK = 8'hFB;
   localparam logic [7:0] HI_MASK     = 8'hF0;

   // controller nibbles and commands
   localparam logic [7:0] INIT_NIB_A    = 8'h30;
   localparam logic [7:0] INIT_NIB_B    = 8'h20;
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
   localparam logic [7:0] CMD_SET_CGRAM = 8'h40;

   localparam logic [7:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
   localparam logic [7:0] INIT_CMDS  [6] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C, 8'h0F};
   localparam logic [7:0] CLEAR_CMDS [2] = '{8'h01, 8'h02};

   localparam logic [2:0] INIT_LAST_IDX  = 3'd5;
   localparam logic [2:0] CLEAR_LAST_IDX = 3'd1;
   localparam logic [2:0] SINGLE_LAST_IDX = 3'd0;

   // step positions inside the write sequences
   localparam logic [2:0] PRE_PUT_A      = 3'd0;
   localparam logic [2:0] PRE_PUT_B      = 3'd3;
   localparam logic [2:0] PRE_LAST_STEP  = 3'd7;
   localparam logic [2:0] STEP_HI        = 3'd0;
   localparam logic [2:0] STEP_LO        = 3'd3;
   localparam logic [2:0] STEP_BL        = 3'd6;
   localparam logic [2:0] SEND_LAST_STEP = 3'd6;
   localparam logic [2:0] STRB_RISE_STEP = 3'd0;
   localparam logic [2:0] STRB_LAST_STEP = 3'd1;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ACT_INIT   = 3'd0,
      ACT_CMD    = 3'd1,
      ACT_DATA   = 3'd2,
      ACT_CURSOR = 3'd3,
      ACT_CLEAR  = 3'd4,
      ACT_GLYPH  = 3'd5,
      ACT_STROBE = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      KIND_INIT   = 2'd0,
      KIND_SEND   = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_STROBE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       rs;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } desc_flow_type;

endpackage

// File: hdl/clnw_req_if.sv
// request channel: one action word per handshake
interface clnw_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] value;
   logic [5:0] column;
   logic [1:0] row;
   logic [2:0] glyph_slot;

   modport source (output valid, output action, output value, output column,
                   output row, output glyph_slot, input ready);
   modport sink   (input valid, input action, input value, input column,
                   input row, input glyph_slot, output ready);
endinterface

// File: hdl/clnw_rsp_if.sv
// response channel: one expander byte per word
interface clnw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] port_byte;
   logic       last;

   modport source (output valid, output port_byte, output last, input ready);
   modport sink   (input valid, input port_byte, input last, output ready);
endinterface

// File: hdl/clnw_front.sv
// front end: accepts action words and turns them into sequencer descriptors
module clnw_front (
   clnw_req_if.sink                 req,
   input  logic                     queue_full,
   output clnw_pkg::desc_flow_type  push
);

   clnw_pkg::action_type act;
   logic                 act_ok;
   logic [7:0]           cursor_addr;

   assign act         = clnw_pkg::action_type'(req.action);
   assign cursor_addr = {2'b00, req.column} + clnw_pkg::ROW_OFFSET[req.row];
   assign req.ready   = !queue_full;

   always_comb begin
      act_ok          = 1'b1;
      push.desc.kind  = clnw_pkg::KIND_SEND;
      push.desc.value = req.value;
      push.desc.rs    = 1'b0;
      unique case (act)
         clnw_pkg::ACT_INIT: begin
            push.desc.kind = clnw_pkg::KIND_INIT;
         end
         clnw_pkg::ACT_CMD: begin
            push.desc.value = req.value;
         end
         clnw_pkg::ACT_DATA: begin
            push.desc.rs = 1'b1;
         end
         clnw_pkg::ACT_CURSOR: begin
            push.desc.value = clnw_pkg::CMD_SET_DDRAM | cursor_addr;
         end
         clnw_pkg::ACT_CLEAR: begin
            push.desc.kind = clnw_pkg::KIND_CLEAR;
         end
         clnw_pkg::ACT_GLYPH: begin
            push.desc.value = clnw_pkg::CMD_SET_CGRAM | {2'b00, req.glyph_slot, 3'b000};
         end
         clnw_pkg::ACT_STROBE: begin
            push.desc.kind = clnw_pkg::KIND_STROBE;
         end
         default: begin
            // unused action code: taken and dropped
            act_ok = 1'b0;
         end
      endcase
      push.valid = req.valid && !queue_full && act_ok;
   end

endmodule

// File: hdl/clnw_queue.sv
// short descriptor queue between front end and sequencer
module clnw_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  clnw_pkg::desc_flow_type  push,
   output logic                     full,
   output clnw_pkg::desc_flow_type  head,
   input  logic                     pop
);

   localparam int PTR_W = $clog2(clnw_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(clnw_pkg::QUEUE_DEPTH + 1);

   clnw_pkg::desc_type entries_ff [clnw_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(clnw_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.desc  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(clnw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(clnw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.desc;
      end
   end

endmodule

// File: hdl/clnw_back.sv
// back end: expands descriptors into expander bytes, one per cycle unless the receiver stalls
module clnw_back (
   input  logic                     clock,
   input  logic                     reset,
   input  clnw_pkg::desc_flow_type  head,
   output logic                     pop,
   clnw_rsp_if.source               rsp
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PRE  = 4'b0010,
      ST_SEND = 4'b0100,
      ST_STRB = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic [2:0]         idx_ff, idx_in;
   clnw_pkg::desc_type desc_ff, desc_in;
   logic [7:0]         shadow_ff, shadow_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff;
   logic               out_last_ff;

   logic       out_free, fire, seg_done, item_done;
   logic [7:0] cur_byte, step_byte, rise_byte, fall_byte;
   logic [2:0] last_idx;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign fire      = (state_ff != ST_IDLE) && out_free;
   assign rise_byte = shadow_ff | clnw_pkg::EN_BIT | clnw_pkg::BL_BIT;
   assign fall_byte = (shadow_ff & clnw_pkg::EN_CLR_MASK) | clnw_pkg::BL_BIT;

   always_comb begin
      case (desc_ff.kind)
         clnw_pkg::KIND_INIT: begin
            cur_byte = clnw_pkg::INIT_CMDS[idx_ff];
            last_idx = clnw_pkg::INIT_LAST_IDX;
         end
         clnw_pkg::KIND_CLEAR: begin
            cur_byte = clnw_pkg::CLEAR_CMDS[idx_ff[0]];
            last_idx = clnw_pkg::CLEAR_LAST_IDX;
         end
         default: begin
            cur_byte = desc_ff.value;
            last_idx = clnw_pkg::SINGLE_LAST_IDX;
         end
      endcase
   end

   always_comb begin
      step_byte = clnw_pkg::BL_BIT;
      seg_done  = 1'b0;
      item_done = 1'b0;
      unique case (state_ff)
         ST_PRE: begin
            case (step_ff) inside
               clnw_pkg::PRE_PUT_A: step_byte = clnw_pkg::INIT_NIB_A | clnw_pkg::BL_BIT;
               clnw_pkg::PRE_PUT_B: step_byte = clnw_pkg::INIT_NIB_B | clnw_pkg::BL_BIT;
               3'd1, 3'd4, 3'd6:    step_byte = rise_byte;
               default:             step_byte = fall_byte;
            endcase
            seg_done = (step_ff == clnw_pkg::PRE_LAST_STEP);
         end
         ST_SEND: begin
            case (step_ff) inside
               clnw_pkg::STEP_HI: begin
                  step_byte = (cur_byte & clnw_pkg::HI_MASK) | clnw_pkg::BL_BIT
                              | (desc_ff.rs ? clnw_pkg::RS_BIT : 8'h00);
               end
               clnw_pkg::STEP_LO: begin
                  step_byte = {cur_byte[3:0], 4'b0000} | clnw_pkg::BL_BIT
                              | (desc_ff.rs ? clnw_pkg::RS_BIT : 8'h00);
               end
               clnw_pkg::STEP_BL: step_byte = clnw_pkg::BL_BIT;
               3'd1, 3'd4:        step_byte = rise_byte;
               default:           step_byte = fall_byte;
            endcase
            seg_done  = (step_ff == clnw_pkg::SEND_LAST_STEP);
            item_done = seg_done && (idx_ff == last_idx);
         end
         ST_STRB: begin
            step_byte = (step_ff == clnw_pkg::STRB_RISE_STEP) ? rise_byte : fall_byte;
            seg_done  = (step_ff == clnw_pkg::STRB_LAST_STEP);
            item_done = seg_done;
         end
         ST_IDLE: begin
            step_byte = clnw_pkg::BL_BIT;
         end
         default: begin
            step_byte = clnw_pkg::BL_BIT;
         end
      endcase
   end

   // next descriptor is taken while idle, or as soon as the current one issues its final byte
   assign pop = head.valid && ((state_ff == ST_IDLE) || (fire && item_done));

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      desc_in      = desc_ff;
      shadow_in    = shadow_ff;
      out_valid_in = out_valid_ff;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         out_valid_in = 1'b1;
         shadow_in    = step_byte;
         step_in      = step_ff + 1'b1;
         if (seg_done) begin
            step_in = '0;
            if (state_ff == ST_PRE) begin
               state_in = ST_SEND;
               idx_in   = '0;
            end else if (!item_done) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
      end
      if (pop) begin
         desc_in = head.desc;
         step_in = '0;
         idx_in  = '0;
         case (head.desc.kind)
            clnw_pkg::KIND_INIT:   state_in = ST_PRE;
            clnw_pkg::KIND_STROBE: state_in = ST_STRB;
            default:               state_in = ST_SEND;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         idx_ff       <= '0;
         shadow_ff    <= clnw_pkg::BL_BIT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         shadow_ff    <= shadow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      if (fire) begin
         out_byte_ff <= step_byte;
         out_last_ff <= item_done;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.port_byte = out_byte_ff;
   assign rsp.last      = out_last_ff;

   // backlight stays on in every byte written
   a_backlight_on: assert property (@(posedge clock) disable iff (reset)
      shadow_ff[3])
      else $error("shadow lost backlight bit");

   // a byte issued for the end of an item shows up flagged last
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      fire && item_done |=> out_valid_ff && out_last_ff)
      else $error("final byte not flagged last");

   // a stalled output holds the sequencer position
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready && (state_ff != ST_IDLE) |=> $stable(step_ff) && $stable(idx_ff))
      else $error("sequencer advanced under stall");

   // strobe sequence is two writes long
   a_strb_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STRB) |-> (step_ff <= clnw_pkg::STRB_LAST_STEP))
      else $error("strobe step out of range");

endmodule

// File: hdl/char_lcd_expander_nibble_writer.sv
// top level of the 4-bit lcd writer through an 8-bit port expander
// an action word passes the queue entry, sequencer state and output byte registers
// throughput: one byte per cycle unless the receiver stalls; command, data, cursor and
// glyph are 7 bytes, clear 14, init 50, strobe 2; the byte sequencer sets this pace
// a 2-deep descriptor queue lets action words arrive while the sequencer is busy
// reset: queue empty, sequencer idle, port shadow set to 0x08
module char_lcd_expander_nibble_writer (
   input logic        clock,
   input logic        reset,
   clnw_req_if.sink   req_chan,
   clnw_rsp_if.source rsp_chan
);

   clnw_pkg::desc_flow_type push;
   clnw_pkg::desc_flow_type head;
   logic                    queue_full;
   logic                    pop;

   clnw_front u_front (
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   clnw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   clnw_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

// File: test/tb_char_lcd_expander_nibble_writer.sv
// self-checking testbench of the lcd nibble writer: directed and random actions vs predicted bytes
module tb_char_lcd_expander_nibble_writer;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ACT_UNUSED = 3'd7;
   localparam int RANDOM_WORDS = 310;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int HOLD_AT_WORD = 60;
   localparam int QUIET_TAIL = 40;
   localparam int SETTLE_CYCLES = 30;

   // own copies of the controller tables
   localparam logic [7:0] SETUP_CMDS [6] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C, 8'h0F};
   localparam logic [7:0] LINE_BASE  [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_HOME  = 8'h02;

   typedef struct {
      logic [2:0] action;
      logic [7:0] value;
      logic [5:0] column;
      logic [1:0] row;
      logic [2:0] glyph_slot;
      bit         drain_first;
   } lcd_action_type;

   typedef struct {
      logic [7:0] port_byte;
      logic       last;
   } expander_write_type;

   logic clock;
   logic reset;

   clnw_req_if req_chan ();
   clnw_rsp_if rsp_chan ();

   char_lcd_expander_nibble_writer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lcd_action_type     action_q [$];
   expander_write_type byte_expect_q [$];
   logic [7:0]         port_shadow;
   int                 fail_count;
   int                 word_total;
   int                 words_accepted;
   int                 real_words;
   int                 cycle_count;
   bit                 pause_next;

   function automatic lcd_action_type action_word(logic [2:0] act, logic [7:0] v,
                                                  logic [5:0] c, logic [1:0] r,
                                                  logic [2:0] s);
      lcd_action_type w;
      w.action = act;
      w.value = v;
      w.column = c;
      w.row = r;
      w.glyph_slot = s;
      w.drain_first = 1'b0;
      return w;
   endfunction

   function automatic lcd_action_type random_word(logic [2:0] act);
      return action_word(act, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                         2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
   endfunction

   function void push_word(lcd_action_type w);
      w.drain_first = pause_next;
      pause_next = 1'b0;
      action_q.push_back(w);
      if (w.action != ACT_UNUSED)
         real_words++;
   endfunction

   // expected expander stream
   function void emit_byte(logic [7:0] b);
      expander_write_type e;
      port_shadow = b;
      e.port_byte = b;
      e.last = 1'b0;
      byte_expect_q.push_back(e);
   endfunction

   // enable pulse built on the shadow of the last expected byte
   function void pulse_enable();
      emit_byte(port_shadow | clnw_pkg::EN_BIT | clnw_pkg::BL_BIT);
      emit_byte((port_shadow & clnw_pkg::EN_CLR_MASK) | clnw_pkg::BL_BIT);
   endfunction

   function void send_ctrl_byte(logic [7:0] v, logic [7:0] rs);
      emit_byte(rs | (v & clnw_pkg::HI_MASK) | clnw_pkg::BL_BIT);
      pulse_enable();
      emit_byte(rs | {v[3:0], 4'h0} | clnw_pkg::BL_BIT);
      pulse_enable();
      emit_byte(clnw_pkg::BL_BIT);
   endfunction

   function void predict_writes(lcd_action_type w);
      int n_before;
      n_before = byte_expect_q.size();
      case (w.action)
         clnw_pkg::ACT_INIT: begin
            emit_byte(8'h30 | clnw_pkg::BL_BIT);
            pulse_enable();
            emit_byte(8'h20 | clnw_pkg::BL_BIT);
            pulse_enable();
            pulse_enable();
            foreach (SETUP_CMDS[i])
               send_ctrl_byte(SETUP_CMDS[i], 8'h00);
         end
         clnw_pkg::ACT_CMD:    send_ctrl_byte(w.value, 8'h00);
         clnw_pkg::ACT_DATA:   send_ctrl_byte(w.value, clnw_pkg::RS_BIT);
         // column plus line base wraps at 8 bits
         clnw_pkg::ACT_CURSOR:
            send_ctrl_byte(8'h80 | 8'({2'b00, w.column} + LINE_BASE[w.row]), 8'h00);
         clnw_pkg::ACT_CLEAR: begin
            send_ctrl_byte(CMD_CLEAR, 8'h00);
            send_ctrl_byte(CMD_HOME, 8'h00);
         end
         clnw_pkg::ACT_GLYPH:  send_ctrl_byte(8'h40 | {2'b00, w.glyph_slot, 3'b000}, 8'h00);
         clnw_pkg::ACT_STROBE: pulse_enable();
         default: ;
      endcase
      if (byte_expect_q.size() > n_before)
         byte_expect_q[byte_expect_q.size() - 1].last = 1'b1;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
      fail_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // action driver
   bit             offering;
   int             gap_left;
   lcd_action_type cur_word;

   always @(posedge clock) begin : action_driver
      bit calm;
      calm = (cycle_count % 600) < 150 || words_accepted >= word_total - QUIET_TAIL;
      if (reset) begin
         offering = 1'b0;
         gap_left = 0;
         req_chan.valid <= 1'b0;
         req_chan.action <= clnw_pkg::ACT_INIT;
         req_chan.value <= 8'h00;
         req_chan.column <= 6'd0;
         req_chan.row <= 2'd0;
         req_chan.glyph_slot <= 3'd0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_writes(cur_word);
            words_accepted++;
            offering = 1'b0;
            if (!calm && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 15);
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (action_q.size() > 0 &&
                         (!action_q[0].drain_first || byte_expect_q.size() == 0)) begin
               cur_word = action_q.pop_front();
               offering = 1'b1;
               req_chan.action <= cur_word.action;
               req_chan.value <= cur_word.value;
               req_chan.column <= cur_word.column;
               req_chan.row <= cur_word.row;
               req_chan.glyph_slot <= cur_word.glyph_slot;
            end
         end
         req_chan.valid <= offering;
      end
   end

   // byte monitor and receiver stalls
   int stall_left;
   int hold_left;
   bit hold_done;

   always @(posedge clock) begin : byte_monitor
      expander_write_type want;
      bit calm;
      logic rdy;
      calm = (cycle_count % 600) < 150 || words_accepted >= word_total - QUIET_TAIL;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (byte_expect_q.size() == 0) begin
               report_mismatch("unexpected word", rsp_chan.port_byte, 0);
            end else begin
               want = byte_expect_q.pop_front();
               if (rsp_chan.port_byte !== want.port_byte)
                  report_mismatch("port_byte", rsp_chan.port_byte, want.port_byte);
               if (rsp_chan.last !== want.last)
                  report_mismatch("last", rsp_chan.last, want.last);
            end
         end
         if (!hold_done && words_accepted >= HOLD_AT_WORD) begin
            // long hold so the descriptor queue fills and input backs up
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 15);
         end
         rsp_chan.ready <= rdy;
      end
   end

   initial begin : main_sequence
      int n;
      reset = 1'b1;

      // directed words
      push_word(action_word(clnw_pkg::ACT_INIT, 8'h00, 6'd0, 2'd0, 3'd0));
      push_word(action_word(clnw_pkg::ACT_CMD, 8'h00, 6'd0, 2'd0, 3'd0));
      push_word(action_word(clnw_pkg::ACT_CMD, 8'hFF, 6'd63, 2'd3, 3'd7));
      push_word(action_word(clnw_pkg::ACT_DATA, 8'h00, 6'd0, 2'd0, 3'd0));
      push_word(action_word(clnw_pkg::ACT_DATA, 8'hFF, 6'd63, 2'd3, 3'd7));
      push_word(action_word(clnw_pkg::ACT_DATA, 8'hA5, 6'd21, 2'd1, 3'd2));
      push_word(action_word(clnw_pkg::ACT_CURSOR, 8'h00, 6'd0, 2'd0, 3'd0));
      push_word(action_word(clnw_pkg::ACT_CURSOR, 8'hFF, 6'd39, 2'd1, 3'd7));
      push_word(action_word(clnw_pkg::ACT_CURSOR, 8'h00, 6'd19, 2'd2, 3'd0));
      push_word(action_word(clnw_pkg::ACT_CURSOR, 8'h00, 6'd63, 2'd3, 3'd0));
      // column past the display edge
      push_word(action_word(clnw_pkg::ACT_CURSOR, 8'h00, 6'd45, 2'd3, 3'd0));
      push_word(action_word(clnw_pkg::ACT_CLEAR, 8'h00, 6'd0, 2'd0, 3'd0));
      push_word(action_word(clnw_pkg::ACT_GLYPH, 8'h00, 6'd0, 2'd0, 3'd0));
      push_word(action_word(clnw_pkg::ACT_DATA, 8'h1F, 6'd0, 2'd0, 3'd0));
      push_word(action_word(clnw_pkg::ACT_GLYPH, 8'h00, 6'd0, 2'd0, 3'd7));
      push_word(action_word(clnw_pkg::ACT_STROBE, 8'h00, 6'd0, 2'd0, 3'd0));
      push_word(action_word(clnw_pkg::ACT_STROBE, 8'hFF, 6'd63, 2'd3, 3'd7));
      // unused code leaves the shadow alone
      push_word(action_word(ACT_UNUSED, 8'hFF, 6'd63, 2'd3, 3'd7));
      push_word(action_word(clnw_pkg::ACT_STROBE, 8'h00, 6'd0, 2'd0, 3'd0));
      push_word(action_word(clnw_pkg::ACT_DATA, 8'h5A, 6'd0, 2'd0, 3'd0));
      push_word(action_word(ACT_UNUSED, 8'h00, 6'd0, 2'd0, 3'd0));
      push_word(action_word(clnw_pkg::ACT_STROBE, 8'h00, 6'd0, 2'd0, 3'd0));

      // random part, mostly typical host sequences
      pause_next = 1'b1;
      while (real_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 30) == 0)
            pause_next = 1'b1;
         case ($urandom_range(0, 9))
            0, 1, 2: push_word(random_word(3'($urandom_range(0, 7))));
            3, 4: begin
               push_word(random_word(clnw_pkg::ACT_GLYPH));
               repeat (8) push_word(random_word(clnw_pkg::ACT_DATA));
            end
            5, 6: begin
               push_word(random_word(clnw_pkg::ACT_CURSOR));
               n = $urandom_range(1, 8);
               repeat (n) push_word(random_word(clnw_pkg::ACT_DATA));
            end
            7: begin
               push_word(random_word(clnw_pkg::ACT_CMD));
               push_word(random_word(clnw_pkg::ACT_STROBE));
            end
            8: begin
               push_word(random_word(clnw_pkg::ACT_CLEAR));
               push_word(random_word(clnw_pkg::ACT_DATA));
            end
            default: push_word(random_word(clnw_pkg::ACT_INIT));
         endcase
      end
      word_total = action_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted < word_total)
         @(posedge clock);
      while (byte_expect_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
hdl/clnw_pkg.sv
hdl/clnw_req_if.sv
hdl/clnw_rsp_if.sv
hdl/clnw_front.sv
hdl/clnw_queue.sv
hdl/clnw_back.sv
hdl/char_lcd_expander_nibble_writer.sv
test/tb_char_lcd_expander_nibble_writer.sv
